[rtl/tpsd_pkg.sv]
// Package for the touch point scale and deadband block.
// Holds field widths, register indexes, sequencer states and small helpers.
// No dependencies.
package tpsd_pkg;

  localparam int RAW_W      = 12;
  localparam int POS_W      = 13;
  localparam int SIZE_W     = 12;
  localparam int SPAN_W     = 13;
  localparam int RCNT_W     = 4;
  localparam int CNT_W      = 3;
  localparam int NUM_PORTS  = 5;
  localparam int PROD_W     = SIZE_W + POS_W;
  localparam int DIV_STEPS  = POS_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POINT,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    ORI_NORMAL,
    ORI_SWAP,
    ORI_MIRROR_X,
    ORI_MIRROR_Y
  } orient_t;

  localparam logic [CFG_IDX_W-1:0] REG_ORIENT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX_Y = 3'd5;

  localparam logic [SIZE_W-1:0] RST_WIDTH     = 12'd480;
  localparam logic [SIZE_W-1:0] RST_HEIGHT    = 12'd272;
  localparam logic [SIZE_W-1:0] RST_DEADBAND  = 12'd0;
  localparam logic [SPAN_W-1:0] RST_RAW_MAX_X = 13'd480;
  localparam logic [SPAN_W-1:0] RST_RAW_MAX_Y = 13'd272;

  // Reflect a raw coordinate inside the span; an underflow saturates to zero.
  function automatic logic [POS_W-1:0] mirror_axis(input logic [SPAN_W-1:0] span,
                                                   input logic [RAW_W-1:0] v);
    logic [SPAN_W:0] vp1;
    vp1 = {2'b00, v} + 14'd1;
    if (vp1 > {1'b0, span}) begin
      mirror_axis = '0;
    end else begin
      mirror_axis = POS_W'(span - {1'b0, v} - 13'd1);
    end
  endfunction

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

endpackage

[rtl/touch_point_scale_deadband.sv]
// Top level of the touch point scale and deadband block.
// One shared multiplier and restoring divider step under a small sequencer.
// Depends on tpsd_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in_     | input     | in_valid/in_ready   | raw_count, raw_x0..raw_y4
//  out_    | output    | out_valid/out_ready | touch_count, pos_x0..pos_y4
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A reported point passes one dispatch step, per axis one multiply, one range check
// and 13 divider steps, then one deadband decision; an axis whose quotient
// saturates skips its divider steps. A point not reported takes only the
// dispatch step. The input is ready only while the sequencer idles.
// The finished result sits in an output register, so a new transfer is taken
// while it waits; the next result then holds in its last cycle until the earlier
// one is transferred. Reset is synchronous; held positions have no reset and are
// guarded by the per-point seen bits. cfg_ready is always high.
module touch_point_scale_deadband #(
  parameter int MAX_POINTS = 5,
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tpsd_pkg::RCNT_W-1:0]          in_raw_count,
  input  logic [tpsd_pkg::RAW_W-1:0]           in_raw_x0,
  input  logic [tpsd_pkg::RAW_W-1:0]           in_raw_y0,
  input  logic [tpsd_pkg::RAW_W-1:0]           in_raw_x1,
  input  logic [tpsd_pkg::RAW_W-1:0]           in_raw_y1,
  input  logic [tpsd_pkg::RAW_W-1:0]           in_raw_x2,
  input  logic [tpsd_pkg::RAW_W-1:0]           in_raw_y2,
  input  logic [tpsd_pkg::RAW_W-1:0]           in_raw_x3,
  input  logic [tpsd_pkg::RAW_W-1:0]           in_raw_y3,
  input  logic [tpsd_pkg::RAW_W-1:0]           in_raw_x4,
  input  logic [tpsd_pkg::RAW_W-1:0]           in_raw_y4,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tpsd_pkg::CNT_W-1:0]           out_touch_count,
  output logic [tpsd_pkg::POS_W-1:0]           out_pos_x0,
  output logic [tpsd_pkg::POS_W-1:0]           out_pos_y0,
  output logic [tpsd_pkg::POS_W-1:0]           out_pos_x1,
  output logic [tpsd_pkg::POS_W-1:0]           out_pos_y1,
  output logic [tpsd_pkg::POS_W-1:0]           out_pos_x2,
  output logic [tpsd_pkg::POS_W-1:0]           out_pos_y2,
  output logic [tpsd_pkg::POS_W-1:0]           out_pos_x3,
  output logic [tpsd_pkg::POS_W-1:0]           out_pos_y3,
  output logic [tpsd_pkg::POS_W-1:0]           out_pos_x4,
  output logic [tpsd_pkg::POS_W-1:0]           out_pos_y4,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tpsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tpsd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tpsd_pkg::*;

  localparam int PT_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int MASK_W = (COORD_BITS < RAW_W) ? COORD_BITS : RAW_W;
  localparam logic [RAW_W-1:0] CMASK = RAW_W'((64'd1 << MASK_W) - 64'd1);
  localparam logic [PT_W-1:0]  PT_LAST = PT_W'(MAX_POINTS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_STEPS - 1);

  // Configuration registers.
  orient_t             orient_r;
  logic [SIZE_W-1:0]   width_r;
  logic [SIZE_W-1:0]   height_r;
  logic [SIZE_W-1:0]   deadband_r;
  logic [SPAN_W-1:0]   max_x_r;
  logic [SPAN_W-1:0]   max_y_r;

  // Sequencer and shared unit.
  state_t              state_r, state_nxt;
  logic [PT_W-1:0]     pt_r, pt_nxt;
  logic                axis_r, axis_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [POS_W-1:0]    rem_r, rem_nxt;
  logic [POS_W-1:0]    dvd_r, dvd_nxt;
  logic [POS_W-1:0]    sx_r, sx_nxt;
  logic [POS_W-1:0]    sy_r, sy_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]    out_cnt_r;

  // Per-point storage.
  logic [RAW_W-1:0]    raw_x_r  [MAX_POINTS];
  logic [RAW_W-1:0]    raw_y_r  [MAX_POINTS];
  logic [POS_W-1:0]    held_x_r [MAX_POINTS];
  logic [POS_W-1:0]    held_y_r [MAX_POINTS];
  logic [MAX_POINTS-1:0] seen_r;
  logic [POS_W-1:0]    work_x_r [MAX_POINTS];
  logic [POS_W-1:0]    work_y_r [MAX_POINTS];
  logic [POS_W-1:0]    out_x_r  [MAX_POINTS];
  logic [POS_W-1:0]    out_y_r  [MAX_POINTS];

  logic [RAW_W-1:0]    raw_x_in [NUM_PORTS];
  logic [RAW_W-1:0]    raw_y_in [NUM_PORTS];
  logic [POS_W-1:0]    pos_x_o  [NUM_PORTS];
  logic [POS_W-1:0]    pos_y_o  [NUM_PORTS];

  // Combinational datapath signals.
  logic                accept;
  logic                out_load;
  logic                pt_active;
  logic                pt_last;
  logic [POS_W-1:0]    unseen_x, unseen_y;
  logic [POS_W-1:0]    hx, hy;
  logic [POS_W-1:0]    ox, oy;
  logic [POS_W-1:0]    v_sel;
  logic [SIZE_W-1:0]   size_sel;
  logic [SPAN_W-1:0]   span_sel;
  logic                ovf;
  logic [POS_W:0]      trial;
  logic                ge;
  logic                moved;
  logic                raw_we, work_we, held_we;
  logic [POS_W-1:0]    work_x_wd, work_y_wd;

  assign raw_x_in[0] = in_raw_x0;
  assign raw_y_in[0] = in_raw_y0;
  assign raw_x_in[1] = in_raw_x1;
  assign raw_y_in[1] = in_raw_y1;
  assign raw_x_in[2] = in_raw_x2;
  assign raw_y_in[2] = in_raw_y2;
  assign raw_x_in[3] = in_raw_x3;
  assign raw_y_in[3] = in_raw_y3;
  assign raw_x_in[4] = in_raw_x4;
  assign raw_y_in[4] = in_raw_y4;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_touch_count = out_cnt_r;

  assign pt_last   = (pt_r == PT_LAST);
  assign pt_active = (CNT_W'(pt_r) < count_r);

  // A point never accepted reports the screen size plus the deadband plus one.
  assign unseen_x = POS_W'({1'b0, width_r} + {1'b0, deadband_r} + 13'd1);
  assign unseen_y = POS_W'({1'b0, height_r} + {1'b0, deadband_r} + 13'd1);
  assign hx = seen_r[pt_r] ? held_x_r[pt_r] : unseen_x;
  assign hy = seen_r[pt_r] ? held_y_r[pt_r] : unseen_y;

  always_comb begin
    ox = {1'b0, raw_x_r[pt_r]};
    oy = {1'b0, raw_y_r[pt_r]};
    case (orient_r)
      ORI_SWAP: begin
        ox = {1'b0, raw_y_r[pt_r]};
        oy = {1'b0, raw_x_r[pt_r]};
      end
      ORI_MIRROR_X: ox = mirror_axis(max_x_r, raw_x_r[pt_r]);
      ORI_MIRROR_Y: oy = mirror_axis(max_y_r, raw_y_r[pt_r]);
      default: ;
    endcase
  end

  assign v_sel    = axis_r ? oy : ox;
  assign size_sel = axis_r ? height_r : width_r;
  assign span_sel = axis_r ? max_y_r : max_x_r;

  // The quotient fits in 13 bits exactly when the product over 2^13 is below
  // the span, so only 13 divider steps are needed after this check.
  assign ovf   = (span_sel == '0) ||
                 ({1'b0, prod_r[PROD_W-1:POS_W]} >= span_sel);
  assign trial = {rem_r, dvd_r[POS_W-1]};
  assign ge    = (trial >= {1'b0, span_sel});
  assign moved = (abs_diff(sx_r, hx) > {1'b0, deadband_r}) ||
                 (abs_diff(sy_r, hy) > {1'b0, deadband_r});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_POINT;
      ST_POINT: begin
        if (pt_active) begin
          state_nxt = ST_MUL;
        end else if (pt_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL:    state_nxt = ST_CHK;
      ST_CHK: begin
        if (!ovf) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = axis_r ? ST_DECIDE : ST_MUL;
        end
      end
      ST_DIV: begin
        if (dcnt_r == DCNT_LAST) begin
          state_nxt = axis_r ? ST_DECIDE : ST_MUL;
        end
      end
      ST_DECIDE: state_nxt = pt_last ? ST_DONE : ST_POINT;
      ST_DONE:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls and next values.
  always_comb begin
    pt_nxt        = pt_r;
    axis_nxt      = axis_r;
    dcnt_nxt      = dcnt_r;
    count_nxt     = count_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    raw_we        = 1'b0;
    work_we       = 1'b0;
    held_we       = 1'b0;
    work_x_wd     = hx;
    work_y_wd     = hy;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          raw_we    = 1'b1;
          pt_nxt    = '0;
          count_nxt = ({1'b0, in_raw_count} > {2'b00, CNT_MAX}) ?
                      CNT_MAX : CNT_W'(in_raw_count);
        end
      end
      ST_POINT: begin
        if (pt_active) begin
          axis_nxt = 1'b0;
        end else begin
          work_we = 1'b1;
          if (!pt_last) pt_nxt = pt_r + PT_W'(1);
        end
      end
      ST_MUL: prod_nxt = PROD_W'(v_sel) * PROD_W'(size_sel);
      ST_CHK: begin
        if (ovf) begin
          if (axis_r) begin
            sy_nxt = POS_MAX;
          end else begin
            sx_nxt   = POS_MAX;
            axis_nxt = 1'b1;
          end
        end else begin
          rem_nxt  = {1'b0, prod_r[PROD_W-1:POS_W]};
          dvd_nxt  = prod_r[POS_W-1:0];
          dcnt_nxt = '0;
        end
      end
      ST_DIV: begin
        // One restoring step: the quotient bit shifts in where the dividend
        // bit left, so dvd_r holds the quotient after the last step.
        rem_nxt  = ge ? POS_W'(trial - {1'b0, span_sel}) : POS_W'(trial);
        dvd_nxt  = {dvd_r[POS_W-2:0], ge};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_LAST) begin
          if (axis_r) begin
            sy_nxt = dvd_nxt;
          end else begin
            sx_nxt   = dvd_nxt;
            axis_nxt = 1'b1;
          end
        end
      end
      ST_DECIDE: begin
        work_we = 1'b1;
        if (moved) begin
          held_we   = 1'b1;
          work_x_wd = sx_r;
          work_y_wd = sy_r;
        end
        if (!pt_last) pt_nxt = pt_r + PT_W'(1);
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      orient_r    <= ORI_NORMAL;
      width_r     <= RST_WIDTH;
      height_r    <= RST_HEIGHT;
      deadband_r  <= RST_DEADBAND;
      max_x_r     <= RST_RAW_MAX_X;
      max_y_r     <= RST_RAW_MAX_Y;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (held_we) seen_r[pt_r] <= 1'b1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ORIENT:    orient_r   <= orient_t'(cfg_data[1:0]);
          REG_WIDTH:     width_r    <= cfg_data[SIZE_W-1:0];
          REG_HEIGHT:    height_r   <= cfg_data[SIZE_W-1:0];
          REG_DEADBAND:  deadband_r <= cfg_data[SIZE_W-1:0];
          REG_RAW_MAX_X: max_x_r    <= cfg_data[SPAN_W-1:0];
          REG_RAW_MAX_Y: max_y_r    <= cfg_data[SPAN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pt_r    <= pt_nxt;
    axis_r  <= axis_nxt;
    dcnt_r  <= dcnt_nxt;
    count_r <= count_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    if (raw_we) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        raw_x_r[k] <= raw_x_in[k] & CMASK;
        raw_y_r[k] <= raw_y_in[k] & CMASK;
      end
    end
    if (held_we) begin
      held_x_r[pt_r] <= sx_r;
      held_y_r[pt_r] <= sy_r;
    end
    if (work_we) begin
      work_x_r[pt_r] <= work_x_wd;
      work_y_r[pt_r] <= work_y_wd;
    end
    if (out_load) begin
      out_cnt_r <= count_r;
      out_x_r   <= work_x_r;
      out_y_r   <= work_y_r;
    end
  end

  // Ports beyond the MAX_POINTS parameter always report zero.
  for (genvar k = 0; k < NUM_PORTS; k++) begin : g_pos
    if (k < MAX_POINTS) begin : g_live
      assign pos_x_o[k] = out_x_r[k];
      assign pos_y_o[k] = out_y_r[k];
    end else begin : g_zero
      assign pos_x_o[k] = '0;
      assign pos_y_o[k] = '0;
    end
  end

  assign out_pos_x0 = pos_x_o[0];
  assign out_pos_y0 = pos_y_o[0];
  assign out_pos_x1 = pos_x_o[1];
  assign out_pos_y1 = pos_y_o[1];
  assign out_pos_x2 = pos_x_o[2];
  assign out_pos_y2 = pos_y_o[2];
  assign out_pos_x3 = pos_x_o[3];
  assign out_pos_y3 = pos_y_o[3];
  assign out_pos_x4 = pos_x_o[4];
  assign out_pos_y4 = pos_y_o[4];

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_POINT)
    else $error("sequencer did not start after an input transfer");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < span_sel)
    else $error("divider remainder reached the span");

  a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> dcnt_r <= DCNT_LAST)
    else $error("divider step count ran past the last step");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished result was not presented");

  a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !out_load)
    else $error("output register overwritten before its transfer");

endmodule
